>>> src/size_class_block_allocator_core_assert.svh
// Assertion macros for the size class allocator.
// SCBA_ASSERT_IMP checks cons in the same cycle as ante, SCBA_ASSERT_NXT in the cycle after.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SCBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scba: assertion failed");
`define SCBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scba: assertion failed");
`else
`define SCBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/scba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scba_pkg;

  localparam int SUPERBLOCK_BYTES = 4096;
  localparam int NUM_SUPERBLOCKS  = 64;
  localparam int NUM_HEAPS        = 4;
  localparam int NUM_CLASSES      = 4;

  localparam int UNIT_BYTES = 16;
  localparam int UNIT_SHIFT = 4;

  // fixed field widths
  localparam int ADDR_W = 18;
  localparam int SIZE_W = 8;
  localparam int HEAP_W = 2;
  localparam int STAT_W = 2;

  localparam int NUM_UNITS = (NUM_SUPERBLOCKS * SUPERBLOCK_BYTES) / UNIT_BYTES;
  localparam int UNIT_W    = $clog2(NUM_UNITS);
  localparam int SB_SHIFT  = $clog2(SUPERBLOCK_BYTES);
  localparam int SBU_W     = SB_SHIFT - UNIT_SHIFT;        // units per superblock, log2
  localparam int SB_W      = (NUM_SUPERBLOCKS > 1) ? $clog2(NUM_SUPERBLOCKS) : 1;
  localparam int SBA_W     = ADDR_W - SB_SHIFT;            // superblock number in an address
  localparam int USED_W    = $clog2(NUM_SUPERBLOCKS + 1);
  localparam int HWM_W     = SB_SHIFT + 1;
  localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int NUM_LISTS = NUM_HEAPS * NUM_CLASSES;
  localparam int HIDX_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int MAX_SIZE  = UNIT_BYTES << (NUM_CLASSES - 1);
  localparam int CMP_W     = 20;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_OUTSIDE   = 2'd3
  } stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } st_t;

  typedef struct packed {
    logic              vld;
    logic [UNIT_W-1:0] unit;
  } link_t;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [HEAP_W-1:0] owner;
    logic [HWM_W-1:0]  hwm;
  } sb_info_t;

  // classified request as it travels through the queue
  typedef struct packed {
    logic              action;
    logic              too_large;
    logic [CLS_W-1:0]  cls;
    logic [HEAP_W-1:0] heap;
    logic [UNIT_W-1:0] unit;
    logic [SBA_W-1:0]  sb;
  } q_item_t;

  function automatic logic [UNIT_W-1:0] class_units(input logic [CLS_W-1:0] cls);
    class_units = UNIT_W'(1) << cls;
  endfunction

  function automatic logic [HWM_W:0] class_bytes(input logic [CLS_W-1:0] cls);
    class_bytes = (HWM_W + 1)'(UNIT_BYTES) << cls;
  endfunction

endpackage
`default_nettype wire

>>> src/scba_front.sv
`timescale 1ns / 1ps
`default_nettype none
module scba_front (
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic                       in_action,
  input  wire logic [scba_pkg::SIZE_W-1:0] in_request_size,
  input  wire logic [scba_pkg::HEAP_W-1:0] in_heap_select,
  input  wire logic [scba_pkg::ADDR_W-1:0] in_free_address,
  output logic                            q_push,
  output scba_pkg::q_item_t               q_item
);
  import scba_pkg::*;

  logic [CLS_W-1:0] cls;

  // round size up to its class; size zero lands in the smallest class
  always_comb begin
    cls = '0;
    for (int c = 0; c < NUM_CLASSES - 1; c++) begin
      if (CMP_W'(in_request_size) > CMP_W'(UNIT_BYTES << c)) begin
        cls = CLS_W'(c + 1);
      end
    end
  end

  always_comb begin
    q_push           = start && !busy;
    q_item.action    = in_action;
    q_item.too_large = CMP_W'(in_request_size) > CMP_W'(MAX_SIZE);
    q_item.cls       = cls;
    q_item.heap      = in_heap_select;
    q_item.unit      = in_free_address[UNIT_SHIFT +: UNIT_W];
    q_item.sb        = in_free_address[SB_SHIFT +: SBA_W];
  end

endmodule
`default_nettype wire

>>> src/scba_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module scba_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire scba_pkg::q_item_t item_in,
  input  wire logic              pop,
  output scba_pkg::q_item_t      item_out,
  output logic                   full,
  output logic                   empty
);
  import scba_pkg::*;

  q_item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    full     = cnt_r == QCNT_W'(QUEUE_DEPTH);
    empty    = cnt_r == '0;
    item_out = slot_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

>>> src/scba_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "size_class_block_allocator_core_assert.svh"
module scba_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire scba_pkg::q_item_t           q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  output logic [scba_pkg::ADDR_W-1:0]      out_blk_addr,
  output logic [scba_pkg::STAT_W-1:0]      out_status
);
  import scba_pkg::*;

  st_t                 state_r, state_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;
  q_item_t             item_r, item_nxt;
  logic [HIDX_W-1:0]   hidx_r, hidx_nxt;
  logic [UNIT_W-1:0]   blk_r, blk_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  stat_t               out_stat_r, out_stat_nxt;

  // list heads: flops with valid bits, one write port
  logic                head_vld_r  [NUM_LISTS];
  logic [UNIT_W-1:0]   head_unit_r [NUM_LISTS];
  logic                head_we;
  logic [HIDX_W-1:0]   head_widx;
  link_t               head_wval;
  logic [HIDX_W-1:0]   hd_ridx;
  link_t               hd;

  // next links and superblock table: memories, registered read
  link_t               link_mem [NUM_UNITS];
  link_t               link_rd_r;
  logic                link_we;
  logic [UNIT_W-1:0]   link_waddr;
  link_t               link_wdata;
  logic [UNIT_W-1:0]   link_raddr;

  sb_info_t            info_mem [NUM_SUPERBLOCKS];
  sb_info_t            info_rd_r;
  logic                info_we;
  logic [SB_W-1:0]     info_waddr;
  sb_info_t            info_wdata;
  logic [SB_W-1:0]     info_raddr;

  logic [HIDX_W-1:0]   q_hidx;
  logic [HIDX_W-1:0]   free_idx;
  logic [UNIT_W-1:0]   claim_base;
  logic [HWM_W:0]      csize_b;
  logic [HWM_W:0]      hwm_sum;
  logic [UNIT_W:0]     off_sum;
  logic [UNIT_W-1:0]   nxt_unit;

  always_comb begin
    q_hidx   = HIDX_W'(q_item.heap) * HIDX_W'(NUM_CLASSES) + HIDX_W'(q_item.cls);
    free_idx = HIDX_W'(info_rd_r.owner) * HIDX_W'(NUM_CLASSES) + HIDX_W'(info_rd_r.cls);
    hd_ridx  = (state_r == ST_EXEC && item_r.action == ACT_FREE) ? free_idx : q_hidx;
    hd.vld   = head_vld_r[hd_ridx];
    hd.unit  = head_unit_r[hd_ridx];
    claim_base = {used_r[SB_W-1:0], {SBU_W{1'b0}}};
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    item_nxt      = item_r;
    hidx_nxt      = hidx_r;
    blk_nxt       = blk_r;
    out_valid_nxt = 1'b0;
    out_addr_nxt  = '0;
    out_stat_nxt  = STAT_OK;
    q_pop         = 1'b0;
    head_we       = 1'b0;
    head_widx     = hidx_r;
    head_wval     = '0;
    link_we       = 1'b0;
    link_waddr    = item_r.unit;
    link_wdata    = '0;
    link_raddr    = hd.unit;
    info_we       = 1'b0;
    info_waddr    = blk_r[SBU_W +: SB_W];
    info_wdata    = info_rd_r;
    info_raddr    = q_item.sb[SB_W-1:0];
    csize_b       = class_bytes(item_r.cls);
    hwm_sum       = (HWM_W + 1)'(info_rd_r.hwm) + csize_b;
    off_sum       = (UNIT_W + 1)'(blk_r[SBU_W-1:0]) + (UNIT_W + 1)'(class_units(item_r.cls));
    nxt_unit      = blk_r + class_units(item_r.cls);

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          hidx_nxt = q_hidx;
          csize_b  = class_bytes(q_item.cls);
          if (q_item.action == ACT_FREE) begin
            if (CMP_W'(q_item.sb) >= CMP_W'(used_r)) begin
              out_valid_nxt = 1'b1;
              out_stat_nxt  = STAT_OUTSIDE;
            end else begin
              info_raddr = q_item.sb[SB_W-1:0];
              state_nxt  = ST_EXEC;
            end
          end else if (q_item.too_large) begin
            out_valid_nxt = 1'b1;
            out_stat_nxt  = STAT_TOO_LARGE;
          end else if (!hd.vld) begin
            if (used_r >= USED_W'(NUM_SUPERBLOCKS)) begin
              out_valid_nxt = 1'b1;
              out_stat_nxt  = STAT_EXHAUSTED;
            end else begin
              // claim a fresh superblock and carve its first block
              used_nxt         = used_r + USED_W'(1);
              info_we          = 1'b1;
              info_waddr       = used_r[SB_W-1:0];
              info_wdata.cls   = q_item.cls;
              info_wdata.owner = q_item.heap;
              head_we          = 1'b1;
              head_widx        = q_hidx;
              if (csize_b >= (HWM_W + 1)'(SUPERBLOCK_BYTES)) begin
                info_wdata.hwm = HWM_W'(SUPERBLOCK_BYTES);
                head_wval      = '0;
              end else begin
                info_wdata.hwm = HWM_W'(csize_b);
                link_we        = 1'b1;
                link_waddr     = claim_base + class_units(q_item.cls);
                link_wdata     = '0;
                head_wval.vld  = 1'b1;
                head_wval.unit = claim_base + class_units(q_item.cls);
              end
              out_valid_nxt = 1'b1;
              out_addr_nxt  = ADDR_W'({claim_base, {UNIT_SHIFT{1'b0}}});
            end
          end else begin
            blk_nxt    = hd.unit;
            link_raddr = hd.unit;
            info_raddr = hd.unit[SBU_W +: SB_W];
            state_nxt  = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        head_we       = 1'b1;
        if (item_r.action == ACT_FREE) begin
          // push onto the owner's list for the superblock's class
          link_we        = 1'b1;
          link_waddr     = item_r.unit;
          link_wdata     = hd;
          head_widx      = free_idx;
          head_wval.vld  = 1'b1;
          head_wval.unit = item_r.unit;
        end else begin
          out_addr_nxt = ADDR_W'({blk_r, {UNIT_SHIFT{1'b0}}});
          head_widx    = hidx_r;
          if (link_rd_r.vld) begin
            head_wval = link_rd_r;
          end else begin
            // frontier block: bump the high-water mark and carve the next one if it fits
            info_we    = 1'b1;
            info_waddr = blk_r[SBU_W +: SB_W];
            if (hwm_sum >= (HWM_W + 1)'(SUPERBLOCK_BYTES)) begin
              info_wdata.hwm = HWM_W'(SUPERBLOCK_BYTES);
              head_wval      = '0;
            end else begin
              info_wdata.hwm = HWM_W'(hwm_sum);
              if (off_sum < (UNIT_W + 1)'(2 ** SBU_W)) begin
                link_we        = 1'b1;
                link_waddr     = nxt_unit;
                link_wdata     = '0;
                head_wval.vld  = 1'b1;
                head_wval.unit = nxt_unit;
              end else begin
                head_wval = '0;
              end
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_vld_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_we) begin
        head_vld_r[head_widx] <= head_wval.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    hidx_r     <= hidx_nxt;
    blk_r      <= blk_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
    if (head_we) begin
      head_unit_r[head_widx] <= head_wval.unit;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_r <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    info_rd_r <= info_mem[info_raddr];
  end

  assign out_valid    = out_valid_r;
  assign out_blk_addr = out_addr_r;
  assign out_status   = out_stat_r;

  `SCBA_ASSERT_NXT(a_exec_emits, clk, rst_n, state_r == ST_EXEC, out_valid_r)
  `SCBA_ASSERT_IMP(a_fail_zero_addr, clk, rst_n, out_valid_r && out_stat_r != STAT_OK, out_addr_r == '0)
  `SCBA_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, state_r == ST_IDLE && !q_empty)
  `SCBA_ASSERT_IMP(a_used_bound, clk, rst_n, info_we && state_r == ST_IDLE, used_r < USED_W'(NUM_SUPERBLOCKS))

endmodule
`default_nettype wire

>>> src/size_class_block_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Size class block allocator: allocate and free 16/32/64/128-byte blocks from a
// pool of 64 superblocks of 4096 bytes, with one free list per heap and class.
// An item is taken on a clock edge with start high and busy low; busy rises only
// when the two-entry request queue is full. Every item gives exactly one result,
// shown for a single cycle with out_valid high; the receiver cannot stall, so it
// must take each result in that cycle. A rejected request (size too large, free
// outside the pool, pool exhausted) or a superblock claim is settled as soon as
// the back end pops the item; a list pop or a free passes through the execute
// state, which waits on the registered read of the next-link memory and the
// superblock table. The back end pops no new item in the execute state.
// No clearing pass follows reset: reads of the link memory and superblock table
// are only used at entries already written, so the block is ready at once.
module size_class_block_allocator_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_action,
  input  wire logic [scba_pkg::SIZE_W-1:0] in_request_size,
  input  wire logic [scba_pkg::HEAP_W-1:0] in_heap_select,
  input  wire logic [scba_pkg::ADDR_W-1:0] in_free_address,
  output logic                             out_valid,
  output logic [scba_pkg::ADDR_W-1:0]      out_blk_addr,
  output logic [scba_pkg::STAT_W-1:0]      out_status
);
  import scba_pkg::*;

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  q_item_t front_item;
  q_item_t back_item;

  assign busy = q_full;

  // front end: classify size, split the free address
  scba_front u_front (
    .start           (start),
    .busy            (q_full),
    .in_action       (in_action),
    .in_request_size (in_request_size),
    .in_heap_select  (in_heap_select),
    .in_free_address (in_free_address),
    .q_push          (q_push),
    .q_item          (front_item)
  );

  // decouples accept from execution
  scba_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (front_item),
    .pop      (q_pop),
    .item_out (back_item),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back end: list heads, link memory, superblock table
  scba_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_item       (back_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_blk_addr (out_blk_addr),
    .out_status   (out_status)
  );

endmodule
`default_nettype wire
